>>> rtl/tachbb_pkg.sv
// Shared types and constants for the tachometer bang-bang PWM speed controller.
// Depends on nothing; imported by tachbb_core, the top level, the scoreboard and the testbench.
package tachbb_pkg;

  localparam int unsigned StampWidth = 32;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DutyWidth  = 7;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    MODE_EDGE       = 2'd0,
    MODE_PERIOD_END = 2'd1,
    MODE_TICK       = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PERIOD_THRESHOLD = 3'd0,
    REG_WINDOW_LENGTH    = 3'd1,
    REG_DUTY_STOPPED     = 3'd2,
    REG_DUTY_SLOW        = 3'd3,
    REG_DUTY_FAST        = 3'd4,
    REG_STOP_HOLD        = 3'd5,
    REG_START_HOLD       = 3'd6,
    REG_NONE             = 3'd7
  } reg_idx_t;

  localparam logic [StampWidth-1:0] ResetThreshold = 32'd83333;
  localparam logic [CountWidth-1:0] ResetWindow    = 16'd25000;
  localparam logic [DutyWidth-1:0]  ResetDutyStop  = 7'd1;
  localparam logic [DutyWidth-1:0]  ResetDutySlow  = 7'd80;
  localparam logic [DutyWidth-1:0]  ResetDutyFast  = 7'd10;
  localparam logic [CountWidth-1:0] ResetStopHold  = 16'd10000;
  localparam logic [CountWidth-1:0] ResetStartHold = 16'd5000;

  typedef struct packed {
    logic [StampWidth-1:0] period_threshold;
    logic [CountWidth-1:0] window_length;
    logic [DutyWidth-1:0]  duty_stopped;
    logic [DutyWidth-1:0]  duty_slow;
    logic [DutyWidth-1:0]  duty_fast;
    logic [CountWidth-1:0] stop_hold_ticks;
    logic [CountWidth-1:0] start_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [StampWidth-1:0] capture_stamp;
    logic                  pin_level;
  } item_t;

  typedef struct packed {
    logic [DutyWidth-1:0]  duty;
    logic                  pwm_running;
    logic [StampWidth-1:0] measured_period;
    logic                  stall_flag;
  } result_t;

endpackage

>>> rtl/tach_bang_bang_pwm_speed_control.sv
// An accepted item passes through the input register and then the result register.
// One item per cycle while the result side is not stalled; the update is a single pass of compare and add logic.
// A stalled result holds the result register; the input register then takes one more item.
// Reset is synchronous and active high; it clears the handshake and loads all state and
// configuration registers with their documented reset values.
// Top level: configuration registers, input and result registers around tachbb_core.
module tach_bang_bang_pwm_speed_control
  import tachbb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [1:0]              mode,
  input  logic [StampWidth-1:0]   capture_stamp,
  input  logic                    pin_level,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [DutyWidth-1:0]    duty,
  output logic                    pwm_running,
  output logic [StampWidth-1:0]   measured_period,
  output logic                    stall_flag,
  input  logic                    cfg_write,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   held;
  logic    held_valid;
  logic    advance;
  result_t result_next;
  result_t result;

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_threshold <= ResetThreshold;
      cfg.window_length    <= ResetWindow;
      cfg.duty_stopped     <= ResetDutyStop;
      cfg.duty_slow        <= ResetDutySlow;
      cfg.duty_fast        <= ResetDutyFast;
      cfg.stop_hold_ticks  <= ResetStopHold;
      cfg.start_hold_ticks <= ResetStartHold;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD_THRESHOLD: cfg.period_threshold <= cfg_data;
        REG_WINDOW_LENGTH:    cfg.window_length    <= cfg_data[CountWidth-1:0];
        REG_DUTY_STOPPED:     cfg.duty_stopped     <= cfg_data[DutyWidth-1:0];
        REG_DUTY_SLOW:        cfg.duty_slow        <= cfg_data[DutyWidth-1:0];
        REG_DUTY_FAST:        cfg.duty_fast        <= cfg_data[DutyWidth-1:0];
        REG_STOP_HOLD:        cfg.stop_hold_ticks  <= cfg_data[CountWidth-1:0];
        REG_START_HOLD:       cfg.start_hold_ticks <= cfg_data[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held.mode          <= mode;
      held.capture_stamp <= capture_stamp;
      held.pin_level     <= pin_level;
    end
  end

  tachbb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .item        (held),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign duty            = result.duty;
  assign pwm_running     = result.pwm_running;
  assign measured_period = result.measured_period;
  assign stall_flag      = result.stall_flag;

  // Every processed item leaves a result waiting for transfer.
  a_advance_fills : assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed item left no result");

  // With the result register empty the input side never holds back.
  a_empty_no_stall : assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while result register empty");

  // The result payload changes only when an item is processed.
  a_result_holds : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(advance)) |-> $stable(result))
    else $error("result changed without a processed item");

endmodule

>>> rtl/tachbb_core.sv
// Controller state and its combinational update for one event.
// Depends on tachbb_pkg; instantiated by tach_bang_bang_pwm_speed_control.
module tachbb_core
  import tachbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    update,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result_next
);

  logic                  first_edge_taken, first_edge_taken_next;
  logic [StampWidth-1:0] first_stamp, first_stamp_next;
  logic [StampWidth-1:0] period_ticks, period_ticks_next;
  logic                  stall_mark, stall_mark_next;
  logic [CountWidth-1:0] window_count, window_count_next;
  logic [DutyWidth-1:0]  duty_reg, duty_reg_next;
  logic                  running, running_next;
  logic                  hold_waiting, hold_waiting_next;
  logic [CountWidth-1:0] hold_count, hold_count_next;

  logic [CountWidth-1:0] window_inc;
  logic [CountWidth-1:0] hold_inc;
  logic [CountWidth-1:0] hold_limit;
  logic                  acting;

  assign window_inc = window_count + 16'd1;
  assign hold_inc   = hold_count + 16'd1;
  assign hold_limit = running ? cfg.stop_hold_ticks : cfg.start_hold_ticks;
  assign acting     = running ? item.pin_level : ~item.pin_level;

  always_comb begin
    first_edge_taken_next = first_edge_taken;
    first_stamp_next      = first_stamp;
    period_ticks_next     = period_ticks;
    stall_mark_next       = stall_mark;
    window_count_next     = window_count;
    duty_reg_next         = duty_reg;
    running_next          = running;
    hold_waiting_next     = hold_waiting;
    hold_count_next       = hold_count;
    case (mode_t'(item.mode))
      MODE_EDGE: begin
        if (!first_edge_taken) begin
          first_stamp_next      = item.capture_stamp;
          first_edge_taken_next = 1'b1;
        end else begin
          if (item.capture_stamp > first_stamp) begin
            period_ticks_next = item.capture_stamp - first_stamp;
          end else if (first_stamp > item.capture_stamp) begin
            // The wrap rule measures from the all-ones value, one tick short.
            period_ticks_next = item.capture_stamp - first_stamp - 32'd1;
          end
          first_edge_taken_next = 1'b0;
          stall_mark_next       = 1'b0;
        end
      end
      MODE_PERIOD_END: begin
        if (running) begin
          window_count_next = window_inc;
          if (window_inc == cfg.window_length) begin
            if (stall_mark) begin
              duty_reg_next = cfg.duty_stopped;
            end else if (period_ticks > cfg.period_threshold) begin
              duty_reg_next = cfg.duty_slow;
            end else begin
              duty_reg_next = cfg.duty_fast;
            end
            window_count_next = '0;
            stall_mark_next   = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (!acting) begin
          hold_waiting_next = 1'b0;
          hold_count_next   = '0;
        end else if (!hold_waiting) begin
          hold_waiting_next = 1'b1;
          hold_count_next   = '0;
        end else begin
          hold_count_next = hold_inc;
          if (hold_inc == hold_limit) begin
            if (running) begin
              running_next = 1'b0;
            end else begin
              duty_reg_next = cfg.duty_fast;
              running_next  = 1'b1;
            end
            hold_waiting_next = 1'b0;
            hold_count_next   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_next.duty            = duty_reg_next;
    result_next.pwm_running     = running_next;
    result_next.measured_period = period_ticks_next;
    result_next.stall_flag      = stall_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_edge_taken <= 1'b0;
      first_stamp      <= '0;
      period_ticks     <= '0;
      stall_mark       <= 1'b1;
      window_count     <= '0;
      duty_reg         <= ResetDutyFast;
      running          <= 1'b1;
      hold_waiting     <= 1'b0;
      hold_count       <= '0;
    end else if (update) begin
      first_edge_taken <= first_edge_taken_next;
      first_stamp      <= first_stamp_next;
      period_ticks     <= period_ticks_next;
      stall_mark       <= stall_mark_next;
      window_count     <= window_count_next;
      duty_reg         <= duty_reg_next;
      running          <= running_next;
      hold_waiting     <= hold_waiting_next;
      hold_count       <= hold_count_next;
    end
  end

endmodule

>>> tb/tachbb_speed_sb_pkg.sv
// Scoreboard for the tachometer bang-bang speed controller: a cycle-free model of the
// controller state that predicts one status per transfer and checks the block's results.
// Depends on tachbb_pkg for the mode, register index and result types.
package tachbb_speed_sb_pkg;
  import tachbb_pkg::*;

  localparam logic [StampWidth-1:0] StampWrap = '1;

  class speed_ctrl_scoreboard;
    logic [StampWidth-1:0] threshold;
    logic [CountWidth-1:0] window_len;
    logic [DutyWidth-1:0]  duty_on_stall;
    logic [DutyWidth-1:0]  duty_on_slow;
    logic [DutyWidth-1:0]  duty_on_fast;
    logic [CountWidth-1:0] stop_hold;
    logic [CountWidth-1:0] start_hold;

    logic                  edge_armed;
    logic [StampWidth-1:0] edge_stamp;
    logic [StampWidth-1:0] period;
    logic                  no_pair;
    logic [CountWidth-1:0] window_cnt;
    logic [DutyWidth-1:0]  duty_now;
    logic                  running;
    logic                  hold_armed;
    logic [CountWidth-1:0] hold_cnt;

    result_t     status_due[$];
    int unsigned mismatches;

    function new();
      threshold     = ResetThreshold;
      window_len    = ResetWindow;
      duty_on_stall = ResetDutyStop;
      duty_on_slow  = ResetDutySlow;
      duty_on_fast  = ResetDutyFast;
      stop_hold     = ResetStopHold;
      start_hold    = ResetStartHold;
      edge_armed    = 1'b0;
      edge_stamp    = '0;
      period        = '0;
      no_pair       = 1'b1;
      window_cnt    = '0;
      duty_now      = ResetDutyFast;
      running       = 1'b1;
      hold_armed    = 1'b0;
      hold_cnt      = '0;
      mismatches    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_PERIOD_THRESHOLD: threshold     = data[StampWidth-1:0];
        REG_WINDOW_LENGTH:    window_len    = data[CountWidth-1:0];
        REG_DUTY_STOPPED:     duty_on_stall = data[DutyWidth-1:0];
        REG_DUTY_SLOW:        duty_on_slow  = data[DutyWidth-1:0];
        REG_DUTY_FAST:        duty_on_fast  = data[DutyWidth-1:0];
        REG_STOP_HOLD:        stop_hold     = data[CountWidth-1:0];
        REG_START_HOLD:       start_hold    = data[CountWidth-1:0];
        default: ;
      endcase
    endfunction

    function void capture_edge(logic [StampWidth-1:0] stamp);
      if (!edge_armed) begin
        edge_stamp = stamp;
        edge_armed = 1'b1;
        return;
      end
      if (stamp > edge_stamp) begin
        period = stamp - edge_stamp;
      end else if (edge_stamp > stamp) begin
        period = StampWrap - edge_stamp + stamp;
      end
      edge_armed = 1'b0;
      no_pair    = 1'b0;
    endfunction

    function void count_pwm_period();
      if (!running) return;
      window_cnt = window_cnt + 1'b1;
      if (window_cnt != window_len) return;
      if (no_pair) begin
        duty_now = duty_on_stall;
      end else if (period > threshold) begin
        duty_now = duty_on_slow;
      end else begin
        duty_now = duty_on_fast;
      end
      window_cnt = '0;
      no_pair    = 1'b1;
    endfunction

    function void sample_pin(logic pin);
      logic                  acting;
      logic [CountWidth-1:0] hold;
      acting = running ? pin : !pin;
      hold   = running ? stop_hold : start_hold;
      if (!acting) begin
        hold_armed = 1'b0;
        hold_cnt   = '0;
        return;
      end
      if (!hold_armed) begin
        hold_armed = 1'b1;
        hold_cnt   = '0;
        return;
      end
      hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt != hold) return;
      if (running) begin
        running = 1'b0;
      end else begin
        duty_now = duty_on_fast;
        running  = 1'b1;
      end
      hold_armed = 1'b0;
      hold_cnt   = '0;
    endfunction

    function void note_item(mode_t m, logic [StampWidth-1:0] stamp, logic pin);
      result_t status;
      case (m)
        MODE_EDGE:       capture_edge(stamp);
        MODE_PERIOD_END: count_pwm_period();
        MODE_TICK:       sample_pin(pin);
        default: ;
      endcase
      status.duty            = duty_now;
      status.pwm_running     = running;
      status.measured_period = period;
      status.stall_flag      = no_pair;
      status_due.push_back(status);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        $error("result transfer with no status outstanding, duty %0d", got.duty);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      if (got.duty !== want.duty) begin
        $error("duty: expected %0d, actual %0d", want.duty, got.duty);
        mismatches++;
      end
      if (got.pwm_running !== want.pwm_running) begin
        $error("pwm_running: expected %0d, actual %0d", want.pwm_running, got.pwm_running);
        mismatches++;
      end
      if (got.measured_period !== want.measured_period) begin
        $error("measured_period: expected %0d, actual %0d", want.measured_period,
               got.measured_period);
        mismatches++;
      end
      if (got.stall_flag !== want.stall_flag) begin
        $error("stall_flag: expected %0d, actual %0d", want.stall_flag, got.stall_flag);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction
  endclass

endpackage

>>> tb/tb_tach_bang_bang_pwm_speed_control.sv
// Top-level testbench for tach_bang_bang_pwm_speed_control: directed and random event
// streams under several register settings, with random gaps on the item channel and random result stalls.
// Depends on tachbb_pkg and on the scoreboard in tachbb_speed_sb_pkg.
module tb_tach_bang_bang_pwm_speed_control;
  import tachbb_pkg::*;
  import tachbb_speed_sb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseItems = 65;

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic [1:0]              mode;
  logic [StampWidth-1:0]   capture_stamp;
  logic                    pin_level;
  logic                    result_valid;
  logic                    result_stall;
  logic [DutyWidth-1:0]    duty;
  logic                    pwm_running;
  logic [StampWidth-1:0]   measured_period;
  logic                    stall_flag;
  logic                    cfg_write;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  speed_ctrl_scoreboard sb;
  bit                   idling = 1'b1;
  bit                   long_hold_req = 1'b0;
  int unsigned          items_moved = 0;
  int unsigned          quiet_cycles = 0;

  tach_bang_bang_pwm_speed_control i_dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .capture_stamp   (capture_stamp),
    .pin_level       (pin_level),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .duty            (duty),
    .pwm_running     (pwm_running),
    .measured_period (measured_period),
    .stall_flag      (stall_flag),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(mode_t m, logic [StampWidth-1:0] stamp, logic pin);
    if (idling && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    mode          <= m;
    capture_stamp <= stamp;
    pin_level     <= pin;
    do @(posedge clk); while (item_stall);
    sb.note_item(m, stamp, pin);
    if (m != MODE_UNUSED) items_moved++;
  endtask

  task automatic tach_edge(logic [StampWidth-1:0] stamp);
    send_item(MODE_EDGE, stamp, 1'($urandom_range(0, 1)));
  endtask

  task automatic pwm_end();
    send_item(MODE_PERIOD_END, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic ms_tick(logic level);
    send_item(MODE_TICK, $urandom, level);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CfgDataWidth-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(logic [StampWidth-1:0] thr, logic [CountWidth-1:0] win,
                               logic [DutyWidth-1:0] d_stop, logic [DutyWidth-1:0] d_slow,
                               logic [DutyWidth-1:0] d_fast, logic [CountWidth-1:0] h_stop,
                               logic [CountWidth-1:0] h_start);
    wait_idle();
    write_reg(REG_PERIOD_THRESHOLD, thr);
    write_reg(REG_WINDOW_LENGTH, win);
    write_reg(REG_DUTY_STOPPED, d_stop);
    write_reg(REG_DUTY_SLOW, d_slow);
    write_reg(REG_DUTY_FAST, d_fast);
    write_reg(REG_STOP_HOLD, h_stop);
    write_reg(REG_START_HOLD, h_start);
    write_reg(REG_NONE, $urandom);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DutyWidth-1:0] pick_duty();
    if ($urandom_range(0, 7) == 0) return DutyWidth'($urandom_range(100, 127));
    return DutyWidth'($urandom_range(0, 99));
  endfunction

  task automatic random_setting();
    apply_setting($urandom_range(1000, 200000),
                  CountWidth'(sb.window_cnt + $urandom_range(1, 6)),
                  pick_duty(), pick_duty(), pick_duty(),
                  CountWidth'($urandom_range(1, 5)), CountWidth'($urandom_range(1, 5)));
  endtask

  task automatic random_burst();
    logic [StampWidth-1:0] first;
    logic [StampWidth-1:0] delta;
    int unsigned           pick;
    int unsigned           len;
    int unsigned           hold;
    logic                  level;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      first = ($urandom_range(0, 3) == 0) ? StampWrap - $urandom_range(0, 1000) : $urandom;
      case ($urandom_range(0, 5))
        0: delta = sb.threshold;
        1: delta = sb.threshold + 1;
        2: delta = $urandom_range(0, sb.threshold);
        3: delta = sb.threshold + 1 + $urandom_range(0, 1000);
        4: delta = '0;
        default: delta = $urandom;
      endcase
      tach_edge(first);
      tach_edge(first + delta);
    end else if (pick < 12) begin
      len = (sb.window_len == 0 || sb.window_len > 6) ? 12 : 2 * sb.window_len;
      repeat ($urandom_range(1, len)) pwm_end();
    end else if (pick < 17) begin
      hold  = sb.running ? sb.stop_hold : sb.start_hold;
      level = sb.running;
      if ($urandom_range(0, 3) == 0) level = ~level;
      len = (hold != 0 && hold <= 6) ? hold + 1 + $urandom_range(0, 1) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
      repeat (len) ms_tick(level);
    end else begin
      send_item(mode_t'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start;
    start = items_moved;
    while (items_moved - start < n) random_burst();
    ms_tick(!sb.running);
  endtask

  task automatic run_directed();
    send_item(MODE_UNUSED, $urandom, 1'b1);
    tach_edge('0);
    tach_edge(StampWrap);
    tach_edge(StampWrap);
    tach_edge('0);
    tach_edge(32'd5);
    tach_edge(32'd5);
    ms_tick(1'b1);
    ms_tick(1'b0);
    apply_setting('0, 16'd1, 7'd0, 7'd99, 7'd127, 16'd1, 16'd1);
    pwm_end();
    pwm_end();
    tach_edge(32'd100);
    tach_edge(32'd50);
    pwm_end();
    ms_tick(1'b1);
    ms_tick(1'b1);
    pwm_end();
    tach_edge(32'd7);
    tach_edge(32'd9);
    ms_tick(1'b0);
    ms_tick(1'b0);
    pwm_end();
    send_item(MODE_UNUSED, $urandom, 1'b0);
  endtask

  initial begin
    logic [StampWidth-1:0] s;
    sb            = new();
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    mode          <= MODE_EDGE;
    capture_stamp <= '0;
    pin_level     <= 1'b0;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_PERIOD_THRESHOLD;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    random_phase(PhaseItems);

    random_setting();
    random_phase(PhaseItems);

    random_setting();
    long_hold_req = 1'b1;
    random_phase(PhaseItems);

    random_setting();
    random_phase(PhaseItems / 2);
    wait_idle();
    random_phase(PhaseItems / 2);

    random_setting();
    random_phase(PhaseItems);

    apply_setting(StampWrap, 16'hffff, 7'd99, 7'd0, 7'd99, 16'hffff, 16'hffff);
    random_phase(PhaseItems);

    // A window and a stop hold of zero stand for 65536, so a short stream sees neither act.
    idling = 1'b0;
    apply_setting($urandom_range(1000, 200000), '0, pick_duty(), pick_duty(), pick_duty(),
                  '0, 16'd1);
    repeat (2) ms_tick(1'b0);
    s = $urandom;
    tach_edge(s);
    tach_edge(s + $urandom_range(0, 400000));
    repeat (20) pwm_end();
    repeat (20) ms_tick(1'b1);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        result_stall <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.duty            = duty;
      got.pwm_running     = pwm_running;
      got.measured_period = measured_period;
      got.stall_flag      = stall_flag;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
